@@ sv/lbm_pkg.sv @@
// Shared constants, types and helper functions for the D2Q9 lattice step unit.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package lbm_pkg;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam int CELL_N = GRID_W * GRID_H;
  localparam int DIST_N = CELL_N * 9;
  localparam int CELL_W = $clog2(CELL_N);
  localparam int ADDR_W = $clog2(DIST_N);
  localparam int X_W    = $clog2(GRID_W);
  localparam int Y_W    = $clog2(GRID_H);

  localparam int VAL_W = 18;  // Q2.16 distribution
  localparam int VEL_W = 17;  // Q1.16 velocity
  localparam int SUM_W = 22;  // moment sums over nine distributions
  localparam int DIR_W = 4;
  localparam int CFG_W = 17;

  localparam logic [DIR_W-1:0] DIR_LAST = 4'd8;

  typedef enum logic [1:0] {
    FN_STEP_INLET = 2'd0,
    FN_STEP_STOP  = 2'd1,
    FN_READ       = 2'd2,
    FN_NONE       = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_INLET_VX = 2'd0,
    REG_INLET_VY = 2'd1,
    REG_DENSITY  = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  // Where one streamed distribution comes from.
  typedef struct packed {
    logic              is_const;
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic [DIR_W-1:0]  sd;
  } stream_src_t;

  function automatic logic signed [VAL_W-1:0] rest_w(input logic [DIR_W-1:0] d);
    logic signed [VAL_W-1:0] w;
    case (d)
      4'd0: w = 18'sd29127;
      4'd1, 4'd3, 4'd5, 4'd7: w = 18'sd7282;
      4'd2, 4'd4, 4'd6, 4'd8: w = 18'sd1820;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic signed [1:0] dir_x(input logic [DIR_W-1:0] d);
    logic signed [1:0] v;
    case (d)
      4'd1, 4'd2, 4'd8: v = 2'sd1;
      4'd4, 4'd5, 4'd6: v = -2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] dir_y(input logic [DIR_W-1:0] d);
    logic signed [1:0] v;
    case (d)
      4'd2, 4'd3, 4'd4: v = 2'sd1;
      4'd6, 4'd7, 4'd8: v = -2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

  // Weight numerator over 36 as a shift: 16, 4 or 1.
  function automatic logic [2:0] wnum_shift(input logic [DIR_W-1:0] d);
    logic [2:0] s;
    case (d)
      4'd0: s = 3'd4;
      4'd1, 4'd3, 4'd5, 4'd7: s = 3'd2;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] dist_addr(input logic [CELL_W-1:0] c,
                                                  input logic [DIR_W-1:0] d);
    return ADDR_W'(c) * ADDR_W'(9) + ADDR_W'(d);
  endfunction

  function automatic stream_src_t src_at(input logic left, input logic right,
                                         input logic top, input logic bot,
                                         input logic [DIR_W-1:0] d);
    stream_src_t s;
    s.is_const = 1'b0;
    s.dx       = 2'sd0;
    s.dy       = 2'sd0;
    s.sd       = d;
    case (d)
      4'd1: begin
        if (left) s.sd = 4'd5;
        else s.dx = -2'sd1;
      end
      4'd2: begin
        if (left && top) s.sd = 4'd6;
        else if (left) s.sd = 4'd4;
        else if (top) s.sd = 4'd8;
        else begin
          s.dx = -2'sd1;
          s.dy = -2'sd1;
        end
      end
      4'd3: begin
        if (top) s.sd = 4'd7;
        else s.dy = -2'sd1;
      end
      4'd4: begin
        if (top) s.sd = 4'd6;
        else if (right) s.is_const = 1'b1;
        else begin
          s.dx = 2'sd1;
          s.dy = -2'sd1;
        end
      end
      4'd5: begin
        if (right) s.is_const = 1'b1;
        else s.dx = 2'sd1;
      end
      4'd6: begin
        if (bot) s.sd = 4'd4;
        else if (right) s.is_const = 1'b1;
        else begin
          s.dx = 2'sd1;
          s.dy = 2'sd1;
        end
      end
      4'd7: begin
        if (bot) s.sd = 4'd3;
        else s.dy = 2'sd1;
      end
      4'd8: begin
        if (left && bot) s.sd = 4'd4;
        else if (left) s.sd = 4'd6;
        else if (bot) s.sd = 4'd2;
        else begin
          s.dx = -2'sd1;
          s.dy = 2'sd1;
        end
      end
      default: s.sd = d;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/lbm_vdiv.sv @@
// Iterative restoring divider for one velocity component: round(num/den) in Q1.16.
// Depends on lbm_pkg. One quotient bit per cycle.
`default_nettype none

module lbm_vdiv (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic signed [lbm_pkg::SUM_W-1:0] num_i,
  input  wire logic signed [lbm_pkg::SUM_W-1:0] den_i,
  output logic                                 done_o,
  output logic signed [lbm_pkg::VEL_W-1:0]     quot_o
);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIN  = 3'b100
  } dv_state_e;

  dv_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [16:0] m_q, m_d;
  logic [23:0] r_q, r_d;
  logic [22:0] dv_q, dv_d;
  logic [16:0] q_q, q_d;
  logic        neg_q, neg_d, sat_q, sat_d, zero_q, zero_d;
  logic signed [lbm_pkg::VEL_W-1:0] res_q, res_d;

  logic signed [22:0] nn;
  logic [21:0]        dd;
  logic signed [40:0] nfull;
  logic [39:0]        mag;
  logic [22:0]        dvn;
  logic [23:0]        rs;
  logic signed [18:0] fin;

  always_comb begin
    nn    = den_i[lbm_pkg::SUM_W-1] ? -23'(num_i) : 23'(num_i);
    dd    = den_i[lbm_pkg::SUM_W-1] ? 22'(-23'(den_i)) : 22'(den_i);
    nfull = (41'(nn) <<< 17) + $signed({19'b0, dd});
    mag   = nfull[40] ? 40'(-nfull) : 40'(nfull);
    dvn   = {dd, 1'b0};
    rs    = {r_q[22:0], m_q[16]};
    fin   = neg_q ? -(19'(q_q) + 19'(r_q != '0)) : 19'(q_q);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    m_d     = m_q;
    r_d     = r_q;
    dv_d    = dv_q;
    q_d     = q_q;
    neg_d   = neg_q;
    sat_d   = sat_q;
    zero_d  = zero_q;
    res_d   = res_q;
    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          zero_d  = (den_i == '0);
          neg_d   = nfull[40];
          sat_d   = (mag >= {dvn, 17'b0});
          dv_d    = dvn;
          r_d     = {1'b0, mag[39:17]};
          m_d     = mag[16:0];
          q_d     = '0;
          cnt_d   = '0;
          state_d = DV_RUN;
        end
      end
      DV_RUN: begin
        if (rs >= {1'b0, dv_q}) begin
          r_d = rs - {1'b0, dv_q};
          q_d = {q_q[15:0], 1'b1};
        end else begin
          r_d = rs;
          q_d = {q_q[15:0], 1'b0};
        end
        m_d   = {m_q[15:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) state_d = DV_FIN;
      end
      DV_FIN: begin
        if (zero_q) res_d = '0;
        else if (sat_q) res_d = neg_q ? -17'sd65536 : 17'sd65535;
        else if (fin > 19'sd65535) res_d = 17'sd65535;
        else if (fin < -19'sd65536) res_d = -17'sd65536;
        else res_d = fin[16:0];
        done_d  = 1'b1;
        state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    r_q    <= r_d;
    dv_q   <= dv_d;
    q_q    <= q_d;
    neg_q  <= neg_d;
    sat_q  <= sat_d;
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

`default_nettype wire

@@ sv/lbm_equil.sv @@
// Seven-stage equilibrium pipeline: one direction of one cell per cycle.
// Depends on lbm_pkg for widths, direction vectors and weights.
`default_nettype none

module lbm_equil (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic [lbm_pkg::DIR_W-1:0]        in_dir_i,
  input  wire logic signed [lbm_pkg::VEL_W-1:0] in_ux_i,
  input  wire logic signed [lbm_pkg::VEL_W-1:0] in_uy_i,
  input  wire logic [lbm_pkg::ADDR_W-1:0]       in_addr_i,
  input  wire logic [lbm_pkg::CFG_W-1:0]        density_i,
  output logic                                  out_valid_o,
  output logic [lbm_pkg::ADDR_W-1:0]            out_addr_o,
  output logic signed [lbm_pkg::VAL_W-1:0]      out_val_o,
  output logic                                  busy_o
);

  localparam int NSTG = 7;
  localparam logic signed [28:0] T_LIM = 29'sd1179648;  // 9 * 2^17
  localparam logic [21:0]        RECIP9 = 22'd3728271; // ceil(2^25 / 9)

  logic [NSTG-1:0] vld_q;
  logic [lbm_pkg::ADDR_W-1:0] addr_q [NSTG];

  logic signed [17:0] s0_eu_q;
  logic signed [lbm_pkg::VEL_W-1:0] s0_ux_q, s0_uy_q;
  logic [lbm_pkg::DIR_W-1:0] s0_dir_q, s1_dir_q, s2_dir_q;
  logic signed [17:0] s1_eu_q;
  logic signed [35:0] s1_eu2_q;
  logic signed [34:0] s1_uu_q;
  logic signed [39:0] s2_p2_q;
  logic signed [41:0] s3_a_q;
  logic [40:0]        s3_b_q;
  logic signed [28:0] s4_t_q;
  logic [43:0]        s5_prod_q;
  logic               s5_hi_q, s5_lo_q;
  logic signed [lbm_pkg::VAL_W-1:0] s6_val_q;

  logic signed [17:0] tx, ty, eu_d;
  logic signed [35:0] eu2;
  logic signed [33:0] sqx, sqy;
  logic signed [39:0] eu40, eu240, uu40, p2_d;
  logic [20:0]        wd;
  logic signed [41:0] a_d;
  logic [40:0]        b_d;
  logic signed [63:0] num;
  logic signed [28:0] uoff;
  logic [43:0]        prod_d;
  logic [18:0]        qraw;

  always_comb begin
    case (lbm_pkg::dir_x(in_dir_i))
      2'sd1:   tx = 18'(in_ux_i);
      -2'sd1:  tx = -18'(in_ux_i);
      default: tx = '0;
    endcase
    case (lbm_pkg::dir_y(in_dir_i))
      2'sd1:   ty = 18'(in_uy_i);
      -2'sd1:  ty = -18'(in_uy_i);
      default: ty = '0;
    endcase
    eu_d = tx + ty;

    eu2 = s0_eu_q * s0_eu_q;
    sqx = s0_ux_q * s0_ux_q;
    sqy = s0_uy_q * s0_uy_q;

    eu40  = 40'(s1_eu_q);
    eu240 = 40'(s1_eu2_q);
    uu40  = 40'(s1_uu_q);
    p2_d  = (40'sd1 <<< 33) + (eu40 <<< 17) + (eu40 <<< 18)
          + (eu240 <<< 3) + eu240 - (uu40 <<< 1) - uu40;

    wd  = 21'(density_i) << lbm_pkg::wnum_shift(s2_dir_q);
    a_d = $signed({1'b0, wd}) * $signed(s2_p2_q[39:20]);
    b_d = wd * s2_p2_q[19:0];

    num = (64'(s3_a_q) <<< 20) + $signed({23'b0, s3_b_q}) + (64'sd36 <<< 32);

    uoff   = s4_t_q + T_LIM;
    prod_d = uoff[21:0] * RECIP9;

    qraw = s5_prod_q[43:25];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q[0] <= in_addr_i;
    for (int i = 1; i < NSTG; i++) addr_q[i] <= addr_q[i-1];

    s0_eu_q  <= eu_d;
    s0_ux_q  <= in_ux_i;
    s0_uy_q  <= in_uy_i;
    s0_dir_q <= in_dir_i;

    s1_eu_q  <= s0_eu_q;
    s1_eu2_q <= eu2;
    s1_uu_q  <= 35'(sqx) + 35'(sqy);
    s1_dir_q <= s0_dir_q;

    s2_p2_q  <= p2_d;
    s2_dir_q <= s1_dir_q;

    s3_a_q <= a_d;
    s3_b_q <= b_d;

    s4_t_q <= num[63:35];

    s5_prod_q <= prod_d;
    s5_hi_q   <= (s4_t_q >= T_LIM);
    s5_lo_q   <= (s4_t_q < -T_LIM);

    if (s5_hi_q) s6_val_q <= 18'sd131071;
    else if (s5_lo_q) s6_val_q <= -18'sd131072;
    else s6_val_q <= 18'(qraw - 19'd131072);
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign out_addr_o  = addr_q[NSTG-1];
  assign out_val_o   = s6_val_q;
  assign busy_o      = |vld_q;

endmodule

`default_nettype wire

@@ sv/lattice_boltzmann_d2q9_step_unit.sv @@
// Top level of the D2Q9 lattice step unit: sequencer, grid and snapshot memories.
// Depends on lbm_pkg, lbm_vdiv and lbm_equil.
`default_nettype none

// The unit keeps a GRID_W x GRID_H grid of nine Q2.16 distributions per cell in
// one synchronous memory and a second memory of the same size that holds the
// collided grid before streaming. A transaction with tuser 0 runs one time step
// with column 0 forced to the inlet equilibrium, tuser 1 runs a step with column
// 0 at rest, tuser 2 reads one distribution, tuser 3 does nothing; every
// transaction returns exactly one result. A step works cell by cell: nine
// reads of the grid memory build the moment sums, two serial dividers (one
// quotient bit per cycle) find the velocity, and the equilibrium pipeline
// writes nine values into the snapshot; columns 0 skips the reads and the
// division. Streaming then reads the snapshot once per distribution and writes
// the grid, after a drain of the equilibrium pipeline. Outside column 0 the
// velocity division and the single read port of each memory set the pace of
// a step. After reset the grid reads as the rest weights without any clearing
// pass: a flag selects the rest weight until the first step has rewritten
// every entry. Configuration writes are taken in any cycle but must only come
// while the unit is idle. The input side accepts a new transaction whenever
// the sequencer is idle, even if the last result still waits in the output
// register.
module lattice_boltzmann_d2q9_step_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [5:0] cell_x, [11:6] cell_y, [15:12] direction
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [17:0] value, [23:18] zero
  output logic [0:0]       m_axis_tuser   // [0] was_read
);

  localparam int ADDR_W = lbm_pkg::ADDR_W;
  localparam int CELL_W = lbm_pkg::CELL_W;
  localparam int X_W    = lbm_pkg::X_W;
  localparam int Y_W    = lbm_pkg::Y_W;
  localparam int VAL_W  = lbm_pkg::VAL_W;
  localparam int VEL_W  = lbm_pkg::VEL_W;
  localparam int SUM_W  = lbm_pkg::SUM_W;
  localparam int DIR_W  = lbm_pkg::DIR_W;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_RDITEM   = 11'b00000000010,
    ST_COL_RD   = 11'b00000000100,
    ST_COL_ACC  = 11'b00000001000,
    ST_COL_DST  = 11'b00000010000,
    ST_COL_DIV  = 11'b00000100000,
    ST_COL_EQ   = 11'b00001000000,
    ST_DRAIN    = 11'b00010000000,
    ST_STR      = 11'b00100000000,
    ST_STR_LAST = 11'b01000000000,
    ST_DONE     = 11'b10000000000
  } st_e;

  // Memories: grid and pre-streaming snapshot.
  logic [VAL_W-1:0] store_mem [lbm_pkg::DIST_N];
  logic [VAL_W-1:0] copy_mem  [lbm_pkg::DIST_N];
  logic [VAL_W-1:0] store_q, copy_q;

  st_e state_q, state_d;
  logic [X_W-1:0]    x_q, x_d;
  logic [Y_W-1:0]    y_q, y_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic [DIR_W-1:0]  d_q, d_d;
  logic              grid_init_q, grid_init_d;
  logic              acc_v_q;
  logic              wr_v_q;
  logic              m_valid_q, m_valid_d;
  logic signed [VEL_W-1:0] ivx_q, ivy_q;
  logic [lbm_pkg::CFG_W-1:0] dens_q;

  logic signed [VEL_W-1:0] ux_q, ux_d, uy_q, uy_d;
  logic signed [SUM_W-1:0] s_q, sx_q, sy_q;
  logic [DIR_W-1:0]        sr_d_q, sr_d_d;
  logic [ADDR_W-1:0]       wr_addr_q;
  logic                    wr_const_q;
  logic signed [VAL_W-1:0] wr_cval_q;
  logic signed [VAL_W-1:0] res_val_q, res_val_d;
  logic                    res_rd_q, res_rd_d;
  logic signed [VAL_W-1:0] m_val_q, m_val_d;
  logic                    m_rd_q, m_rd_d;

  // Input fields.
  logic [5:0]       in_cx, in_cy;
  logic [DIR_W-1:0] in_dir;
  lbm_pkg::func_e   in_func;
  logic             in_acc, in_range;
  logic [ADDR_W-1:0] item_addr, store_raddr, copy_raddr, cell_addr;

  // Cell walk.
  logic left, right, top, bot, last_cell;
  logic [X_W-1:0] nx;
  logic [Y_W-1:0] ny;

  // Datapath.
  logic signed [VAL_W-1:0] stored_val;
  logic signed [SUM_W-1:0] f22, fx22, fy22;
  lbm_pkg::stream_src_t    src;
  logic [CELL_W-1:0]       ncell;

  logic div_start, divx_done, divy_done;
  logic signed [VEL_W-1:0] qx, qy;
  logic eq_valid, eq_busy, eq_busy_out_valid;
  logic [ADDR_W-1:0] eq_addr;
  logic signed [VAL_W-1:0] eq_val;

  assign in_cx   = s_axis_tdata[5:0];
  assign in_cy   = s_axis_tdata[11:6];
  assign in_dir  = s_axis_tdata[15:12];
  assign in_func = lbm_pkg::func_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign in_range  = (int'(in_cx) < lbm_pkg::GRID_W) && (int'(in_cy) < lbm_pkg::GRID_H)
                  && (in_dir <= lbm_pkg::DIR_LAST);
  assign item_addr = lbm_pkg::dist_addr(
      CELL_W'(int'(in_cx) * lbm_pkg::GRID_H + int'(in_cy)), in_dir);

  assign left      = (x_q == '0);
  assign right     = (x_q == X_W'(lbm_pkg::GRID_W - 1));
  assign top       = (y_q == '0);
  assign bot       = (y_q == Y_W'(lbm_pkg::GRID_H - 1));
  assign last_cell = right && bot;
  assign nx        = bot ? x_q + X_W'(1) : x_q;
  assign ny        = bot ? '0 : y_q + Y_W'(1);
  assign cell_addr = lbm_pkg::dist_addr(cell_q, d_q);

  // Until the first step has rewritten the grid, every entry is its rest weight.
  assign stored_val = grid_init_q ? $signed(store_q) : lbm_pkg::rest_w(sr_d_q);

  assign f22 = SUM_W'(stored_val);
  always_comb begin
    case (lbm_pkg::dir_x(sr_d_q))
      2'sd1:   fx22 = f22;
      -2'sd1:  fx22 = -f22;
      default: fx22 = '0;
    endcase
    case (lbm_pkg::dir_y(sr_d_q))
      2'sd1:   fy22 = f22;
      -2'sd1:  fy22 = -f22;
      default: fy22 = '0;
    endcase
  end

  assign src   = lbm_pkg::src_at(left, right, top, bot, d_q);
  assign ncell = CELL_W'(int'(cell_q) + int'(src.dx) * lbm_pkg::GRID_H + int'(src.dy));
  assign copy_raddr  = lbm_pkg::dist_addr(ncell, src.sd);
  assign store_raddr = (state_q == ST_COL_RD) ? cell_addr : item_addr;

  assign div_start = (state_q == ST_COL_DST);
  assign eq_valid  = (state_q == ST_COL_EQ);

  lbm_vdiv u_divx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sx_q),
    .den_i   (s_q),
    .done_o  (divx_done),
    .quot_o  (qx)
  );

  lbm_vdiv u_divy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sy_q),
    .den_i   (s_q),
    .done_o  (divy_done),
    .quot_o  (qy)
  );

  lbm_equil u_equil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (eq_valid),
    .in_dir_i    (d_q),
    .in_ux_i     (ux_q),
    .in_uy_i     (uy_q),
    .in_addr_i   (cell_addr),
    .density_i   (dens_q),
    .out_valid_o (eq_busy_out_valid),
    .out_addr_o  (eq_addr),
    .out_val_o   (eq_val),
    .busy_o      (eq_busy)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    cell_d      = cell_q;
    d_d         = d_q;
    grid_init_d = grid_init_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    sr_d_d      = sr_d_q;
    res_val_d   = res_val_q;
    res_rd_d    = res_rd_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_val_d     = m_val_q;
    m_rd_d      = m_rd_q;

    case (state_q)
      ST_IDLE: begin
        sr_d_d = in_dir;
        if (in_acc) begin
          case (in_func)
            lbm_pkg::FN_STEP_INLET, lbm_pkg::FN_STEP_STOP: begin
              x_d     = '0;
              y_d     = '0;
              cell_d  = '0;
              d_d     = '0;
              // Column 0 takes a forced velocity instead of its own.
              ux_d    = (in_func == lbm_pkg::FN_STEP_INLET) ? ivx_q : '0;
              uy_d    = (in_func == lbm_pkg::FN_STEP_INLET) ? ivy_q : '0;
              state_d = ST_COL_EQ;
            end
            lbm_pkg::FN_READ: begin
              res_val_d = '0;
              res_rd_d  = 1'b1;
              state_d   = in_range ? ST_RDITEM : ST_DONE;
            end
            default: begin
              res_val_d = '0;
              res_rd_d  = 1'b0;
              state_d   = ST_DONE;
            end
          endcase
        end
      end
      ST_RDITEM: begin
        res_val_d = stored_val;
        state_d   = ST_DONE;
      end
      ST_COL_RD: begin
        sr_d_d = d_q;
        if (d_q == lbm_pkg::DIR_LAST) begin
          d_d     = '0;
          state_d = ST_COL_ACC;
        end else begin
          d_d = d_q + DIR_W'(1);
        end
      end
      ST_COL_ACC: state_d = ST_COL_DST;
      ST_COL_DST: state_d = ST_COL_DIV;
      ST_COL_DIV: begin
        if (divx_done && divy_done) begin
          ux_d    = qx;
          uy_d    = qy;
          state_d = ST_COL_EQ;
        end
      end
      ST_COL_EQ: begin
        if (d_q == lbm_pkg::DIR_LAST) begin
          d_d = '0;
          if (last_cell) begin
            x_d     = '0;
            y_d     = '0;
            cell_d  = '0;
            state_d = ST_DRAIN;
          end else begin
            x_d     = nx;
            y_d     = ny;
            cell_d  = cell_q + CELL_W'(1);
            state_d = (nx == '0) ? ST_COL_EQ : ST_COL_RD;
          end
        end else begin
          d_d = d_q + DIR_W'(1);
        end
      end
      ST_DRAIN: begin
        // Hold until the last snapshot write has landed.
        if (!eq_busy) state_d = ST_STR;
      end
      ST_STR: begin
        if (d_q == lbm_pkg::DIR_LAST) begin
          d_d = '0;
          if (last_cell) begin
            state_d = ST_STR_LAST;
          end else begin
            x_d    = nx;
            y_d    = ny;
            cell_d = cell_q + CELL_W'(1);
          end
        end else begin
          d_d = d_q + DIR_W'(1);
        end
      end
      ST_STR_LAST: begin
        grid_init_d = 1'b1;
        res_val_d   = '0;
        res_rd_d    = 1'b0;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_val_d   = res_val_q;
          m_rd_d    = res_rd_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      cell_q      <= '0;
      d_q         <= '0;
      grid_init_q <= 1'b0;
      acc_v_q     <= 1'b0;
      wr_v_q      <= 1'b0;
      m_valid_q   <= 1'b0;
      ivx_q       <= 17'sd6554;
      ivy_q       <= '0;
      dens_q      <= 17'd65536;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      cell_q      <= cell_d;
      d_q         <= d_d;
      grid_init_q <= grid_init_d;
      acc_v_q     <= (state_q == ST_COL_RD);
      wr_v_q      <= (state_q == ST_STR);
      m_valid_q   <= m_valid_d;
      if (cfg_we_i) begin
        case (lbm_pkg::reg_idx_e'(cfg_idx_i))
          lbm_pkg::REG_INLET_VX: ivx_q  <= cfg_data_i;
          lbm_pkg::REG_INLET_VY: ivy_q  <= cfg_data_i;
          lbm_pkg::REG_DENSITY:  dens_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q      <= ux_d;
    uy_q      <= uy_d;
    sr_d_q    <= sr_d_d;
    res_val_q <= res_val_d;
    res_rd_q  <= res_rd_d;
    m_val_q   <= m_val_d;
    m_rd_q    <= m_rd_d;
    // Moment sums: the first direction of a cell restarts them.
    if (acc_v_q) begin
      if (sr_d_q == '0) begin
        s_q  <= f22;
        sx_q <= fx22;
        sy_q <= fy22;
      end else begin
        s_q  <= s_q + f22;
        sx_q <= sx_q + fx22;
        sy_q <= sy_q + fy22;
      end
    end
    wr_addr_q  <= cell_addr;
    wr_const_q <= src.is_const;
    wr_cval_q  <= lbm_pkg::rest_w(d_q);
  end

  // Grid memory: one read port, one write port.
  always_ff @(posedge clk_i) begin
    store_q <= store_mem[store_raddr];
    if (wr_v_q) store_mem[wr_addr_q] <= wr_const_q ? wr_cval_q : copy_q;
  end

  // Snapshot memory: written by the equilibrium pipeline, read by streaming.
  always_ff @(posedge clk_i) begin
    copy_q <= copy_mem[copy_raddr];
    if (eq_busy_out_valid) copy_mem[eq_addr] <= eq_val;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_val_q};
  assign m_axis_tuser  = m_rd_q;

endmodule

`default_nettype wire
